/* hdl/mpsp_pkg.sv */
// ----------------------------------------------------------------------------
// mpsp_pkg
// Types, codes and sizes shared by the multi-page shelf packer.
// ----------------------------------------------------------------------------
package mpsp_pkg;

  // page count and derived widths
  localparam int unsigned MaxPages = 16;
  localparam int unsigned PgW      = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int unsigned OpenW    = $clog2(MaxPages + 1);

  // field widths
  localparam int unsigned DimW    = 14;
  localparam int unsigned PadW    = 12;
  localparam int unsigned PosW    = 13;
  localparam int unsigned PageIxW = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);
  localparam int unsigned CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHEET_W    = 2'd0,
    CFG_SHEET_H    = 2'd1,
    CFG_PAD_PIXELS = 2'd2
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_PLACE = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_PAGE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_PLACE,
    CMD_CLEAR,
    CMD_TOO_LARGE
  } cmd_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } bk_state_e;

  typedef struct packed {
    logic [0:0]      opcode;
    logic [DimW-1:0] rect_width;
    logic [DimW-1:0] rect_height;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [PageIxW-1:0] page_index;
    logic [PosW-1:0]    pos_x;
    logic [PosW-1:0]    pos_y;
  } out_item_t;

  typedef struct packed {
    logic [DimW-1:0] sheet_w;
    logic [DimW-1:0] sheet_h;
    logic [PadW-1:0] pad_pixels;
  } cfg_t;

  // classified request, padded sizes already fit a page when kind is place
  typedef struct packed {
    cmd_kind_e       kind;
    logic [DimW-1:0] pw;
    logic [DimW-1:0] ph;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic             take_clear;
    logic [OpenW-1:0] pages_open;
  } bk_stat_t;

endpackage

/* hdl/mpsp_front.sv */
// ----------------------------------------------------------------------------
// mpsp_front
// Pads an incoming request and sorts it into clear, too large or place.
// ----------------------------------------------------------------------------
module mpsp_front (
  input  mpsp_pkg::in_item_t item_i,
  input  mpsp_pkg::cfg_t     cfg_i,
  output mpsp_pkg::cmd_t     cmd_o
);
  import mpsp_pkg::*;

  logic [DimW:0] pad2;
  logic [DimW:0] pw;
  logic [DimW:0] ph;
  logic          too_large;

  assign pad2      = {2'b00, cfg_i.pad_pixels, 1'b0};
  assign pw        = {1'b0, item_i.rect_width} + pad2;
  assign ph        = {1'b0, item_i.rect_height} + pad2;
  assign too_large = (pw > {1'b0, cfg_i.sheet_w}) || (ph > {1'b0, cfg_i.sheet_h});

  always_comb begin
    cmd_o.pw = pw[DimW-1:0];
    cmd_o.ph = ph[DimW-1:0];
    if (item_i.opcode == OP_CLEAR) begin
      cmd_o.kind = CMD_CLEAR;
    end else if (too_large) begin
      cmd_o.kind = CMD_TOO_LARGE;
    end else begin
      cmd_o.kind = CMD_PLACE;
    end
  end

endmodule

/* hdl/mpsp_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// mpsp_cmd_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module mpsp_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  mpsp_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           valid_o,
  output mpsp_pkg::cmd_t rd_data_o
);
  import mpsp_pkg::*;

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wptr_q, wptr_d;
  logic [CmdPtrW-1:0] rptr_q, rptr_d;
  logic [CmdCntW-1:0] cnt_q, cnt_d;
  logic               do_wr, do_rd;

  assign full_o    = (cnt_q == CmdCntW'(CmdDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

/* hdl/mpsp_back.sv */
// ----------------------------------------------------------------------------
// mpsp_back
// Walks the open pages one a cycle, holds the shelf cursors and the result.
// ----------------------------------------------------------------------------
module mpsp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpsp_pkg::cfg_t      cfg_i,
  input  logic                cmd_valid_i,
  input  mpsp_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output mpsp_pkg::out_item_t out_item_o,
  output logic                empty,
  input  logic                pop,
  output mpsp_pkg::bk_stat_t  stat_o
);
  import mpsp_pkg::*;

  bk_state_e        state_q, state_d;
  logic [PgW-1:0]   pg_q, pg_d;
  logic [DimW-1:0]  pw_q, pw_d;
  logic [DimW-1:0]  ph_q, ph_d;
  logic [OpenW-1:0] pages_open_q, pages_open_d;
  out_item_t        res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic [DimW-1:0]  cur_x_q   [MaxPages];
  logic [DimW-1:0]  cur_y_q   [MaxPages];
  logic [DimW-1:0]  row_tall_q[MaxPages];

  logic             res_free, res_load, clr, page_wr;
  out_item_t        res_new;

  // per-page evaluation
  logic [DimW-1:0]  cx, cy, rt;
  logic             wrap, fits, new_page, last_page;
  logic [DimW:0]    y_adv;
  logic [DimW-1:0]  eff_x, eff_y, eff_rt;
  logic [DimW-1:0]  nx, nrt;

  assign cx = cur_x_q[pg_q];
  assign cy = cur_y_q[pg_q];
  assign rt = row_tall_q[pg_q];

  always_comb begin
    wrap   = ({1'b0, cx} + {1'b0, pw_q}) > {1'b0, cfg_i.sheet_w};
    y_adv  = {1'b0, cy} + {1'b0, rt};
    eff_x  = wrap ? '0 : cx;
    eff_rt = wrap ? '0 : rt;
    eff_y  = cy;
    if (wrap) begin
      eff_y = y_adv[DimW] ? {DimW{1'b1}} : y_adv[DimW-1:0];
    end
    fits  = ({1'b0, eff_y} + {1'b0, ph_q}) <= {1'b0, cfg_i.sheet_h};
    nx    = fits ? eff_x + pw_q : eff_x;
    nrt   = (fits && (ph_q > eff_rt)) ? ph_q : eff_rt;
  end

  // pages past the open count hold zero cursors, so a fresh page needs no reset
  assign new_page  = (OpenW'(pg_q) == pages_open_q);
  assign last_page = (pg_q == PgW'(MaxPages - 1));
  assign res_free  = !res_valid_q || pop;

  always_comb begin
    state_d   = state_q;
    pg_d      = pg_q;
    pw_d      = pw_q;
    ph_d      = ph_q;
    cmd_pop_o = 1'b0;
    res_load  = 1'b0;
    clr       = 1'b0;
    page_wr   = 1'b0;
    res_new   = '{status: ST_OK, page_index: '0, pos_x: '0, pos_y: '0};
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && res_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_CLEAR: begin
              clr      = 1'b1;
              res_load = 1'b1;
            end
            CMD_TOO_LARGE: begin
              res_new.status = ST_TOO_LARGE;
              res_load       = 1'b1;
            end
            CMD_PLACE: begin
              pw_d    = cmd_i.pw;
              ph_d    = cmd_i.ph;
              pg_d    = '0;
              state_d = BK_WALK;
            end
            default: begin
              res_new.status = ST_TOO_LARGE;
              res_load       = 1'b1;
            end
          endcase
        end
      end
      BK_WALK: begin
        page_wr = 1'b1;
        if (fits) begin
          res_new.page_index = PageIxW'(pg_q);
          res_new.pos_x      = PosW'(eff_x) + PosW'(cfg_i.pad_pixels);
          res_new.pos_y      = PosW'(eff_y) + PosW'(cfg_i.pad_pixels);
          res_load           = 1'b1;
          state_d            = BK_IDLE;
        end else if (last_page) begin
          res_new.status = ST_NO_PAGE;
          res_load       = 1'b1;
          state_d        = BK_IDLE;
        end else begin
          pg_d = pg_q + 1'b1;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    pages_open_d = pages_open_q;
    if (clr) begin
      pages_open_d = '0;
    end else if (page_wr && new_page) begin
      pages_open_d = pages_open_q + 1'b1;
    end
    res_d       = res_load ? res_new : res_q;
    res_valid_d = res_load ? 1'b1 : (pop ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      pg_q         <= '0;
      pages_open_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pg_q         <= pg_d;
      pages_open_q <= pages_open_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q  <= pw_d;
    ph_q  <= ph_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxPages; i++) begin
        cur_x_q[i]    <= '0;
        cur_y_q[i]    <= '0;
        row_tall_q[i] <= '0;
      end
    end else if (clr) begin
      for (int i = 0; i < MaxPages; i++) begin
        cur_x_q[i]    <= '0;
        cur_y_q[i]    <= '0;
        row_tall_q[i] <= '0;
      end
    end else if (page_wr) begin
      cur_x_q[pg_q]    <= nx;
      cur_y_q[pg_q]    <= eff_y;
      row_tall_q[pg_q] <= nrt;
    end
  end

  assign out_item_o        = res_q;
  assign empty             = !res_valid_q;
  assign stat_o.busy       = (state_q == BK_WALK);
  assign stat_o.take_clear = clr;
  assign stat_o.pages_open = pages_open_q;

endmodule

/* hdl/multi_page_shelf_packer_top.sv */
// ----------------------------------------------------------------------------
// multi_page_shelf_packer_top
// Shelf packing of padded rectangles over a row of fixed-size pages.
// ----------------------------------------------------------------------------
// channel   direction  handshake             word
// request   in         push / full           in_item_i  (opcode, width, height)
// result    out        empty / pop           out_item_o (status, page, x, y)
// config    in         cfg_we_i, cfg_idx_i   cfg_data_i (no read-back)
//
// Clear and too-large requests are answered from the idle state of the back
// end; a place walks pages from page 0 until one fits or all fail (page walk).
// Requests queue two deep behind the front, so push continues while a result
// waits. Reset clears all cursors and the open page count at once.
// ----------------------------------------------------------------------------
module multi_page_shelf_packer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  mpsp_pkg::in_item_t           in_item_i,
  output logic                         empty,
  input  logic                         pop,
  output mpsp_pkg::out_item_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic [mpsp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mpsp_pkg::DimW-1:0]    cfg_data_i
);
  import mpsp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cmd_t     front_cmd, fifo_cmd;
  logic     fifo_valid, fifo_pop;
  bk_stat_t bk_stat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHEET_W:    cfg_d.sheet_w    = cfg_data_i;
        CFG_SHEET_H:    cfg_d.sheet_h    = cfg_data_i;
        CFG_PAD_PIXELS: cfg_d.pad_pixels = cfg_data_i[PadW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sheet_w: DimW'(1024), sheet_h: DimW'(1024), pad_pixels: PadW'(2)};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mpsp_front u_front (
    .item_i (in_item_i),
    .cfg_i  (cfg_q),
    .cmd_o  (front_cmd)
  );

  mpsp_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (front_cmd),
    .full_o    (full),
    .rd_i      (fifo_pop),
    .valid_o   (fifo_valid),
    .rd_data_o (fifo_cmd)
  );

  mpsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (fifo_cmd),
    .cmd_pop_o   (fifo_pop),
    .out_item_o  (out_item_o),
    .empty       (empty),
    .pop         (pop),
    .stat_o      (bk_stat)
  );

`ifndef SYNTHESIS
  // never more pages open than exist
  a_pages_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pages_open <= OpenW'(MaxPages))
    else $error("open page count beyond page total");

  // a walk only runs while the result slot is free
  a_walk_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.busy |-> empty)
    else $error("page walk with a result still waiting");

  // a clear empties every page on the next edge
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.take_clear |=> (bk_stat.pages_open == '0) && !empty)
    else $error("clear did not reset the open page count");

  // pages open one at a time
  a_open_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bk_stat.pages_open > $past(bk_stat.pages_open))
      |-> (bk_stat.pages_open == $past(bk_stat.pages_open) + 1'b1))
    else $error("open page count jumped");
`endif

endmodule
